// ----- design/shift_register_chain_updater_assert.svh -----
// assertion macros for the shift register chain updater
`ifndef SHIFT_REGISTER_CHAIN_UPDATER_ASSERT_SVH
`define SHIFT_REGISTER_CHAIN_UPDATER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SRCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srcu_pkg.sv -----
// package: word types, controller state and control structs for the chain updater
package srcu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChainW  = 4 * ByteW;
  localparam int unsigned CntW    = 5;
  localparam logic [CntW-1:0] LastGroupTwo = CntW'(ChainW - 1);
  localparam logic [CntW-1:0] LastGroupOne = CntW'(ByteW - 1);

  typedef struct packed {
    logic [7:0] pll_bits;
    logic [4:0] filter_bits;
    logic [3:0] xtal_bits;
    logic [5:0] atten_bits;
    logic [2:0] led_bits;
  } srcu_in_t;

  typedef enum logic {
    KIND_CLOCK  = 1'b0,
    KIND_STROBE = 1'b1
  } srcu_kind_t;

  typedef struct packed {
    logic kind;
    logic data_bit;
    logic latch_one;
    logic latch_two;
    logic last;
  } srcu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_STROBE
  } srcu_state_t;

  typedef struct packed {
    logic load;
    logic emit_bit;
    logic emit_strobe;
  } srcu_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic grp_two_chg;
  } srcu_stat_t;

endpackage

// ----- design/srcu_dp.sv -----
// datapath: byte packing, change detect, chain shift register and output register
module srcu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  srcu_pkg::srcu_in_t  in_data,
  input  srcu_pkg::srcu_cmd_t cmd,
  output srcu_pkg::srcu_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output srcu_pkg::srcu_out_t out_data
);

  logic [srcu_pkg::ByteW-1:0]  prev1_r, prev2_r, prev3_r, prev4_r;
  logic [srcu_pkg::ByteW-1:0]  b1, b2, b3, b4;
  logic [srcu_pkg::ChainW-1:0] chain_r, chain_nxt;
  logic                        le1, le2;
  logic                        le1_r, le2_r;
  logic                        out_valid_r, out_valid_nxt;
  srcu_pkg::srcu_out_t         out_r, out_nxt;

  assign b1 = in_data.pll_bits;
  assign b2 = {2'b00, in_data.filter_bits, in_data.led_bits[0]};
  assign b3 = {3'b000, in_data.xtal_bits, in_data.led_bits[1]};
  assign b4 = {1'b0, in_data.atten_bits, in_data.led_bits[2]};
  assign le1 = (b1 != prev1_r);
  assign le2 = (b2 != prev2_r) || (b3 != prev3_r) || (b4 != prev4_r);

  assign stat.slot_free   = !out_valid_r || !out_stall;
  assign stat.grp_two_chg = le2;

  // byte one goes out or is replaced by dummy zeros; group two leads when changed
  always_comb begin
    chain_nxt = chain_r;
    if (cmd.load) begin
      if (le2) begin
        chain_nxt = {b4, b3, b2, (le1 ? b1 : {srcu_pkg::ByteW{1'b0}})};
      end else begin
        chain_nxt = {(le1 ? b1 : {srcu_pkg::ByteW{1'b0}}),
                     {(srcu_pkg::ChainW - srcu_pkg::ByteW){1'b0}}};
      end
    end else if (cmd.emit_bit) begin
      chain_nxt = {chain_r[srcu_pkg::ChainW-2:0], 1'b0};
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit_bit) begin
      out_nxt.kind      = srcu_pkg::KIND_CLOCK;
      out_nxt.data_bit  = chain_r[srcu_pkg::ChainW-1];
      out_nxt.latch_one = 1'b0;
      out_nxt.latch_two = 1'b0;
      out_nxt.last      = 1'b0;
      out_valid_nxt     = 1'b1;
    end else if (cmd.emit_strobe) begin
      out_nxt.kind      = srcu_pkg::KIND_STROBE;
      out_nxt.data_bit  = 1'b0;
      out_nxt.latch_one = le1_r;
      out_nxt.latch_two = le2_r;
      out_nxt.last      = 1'b1;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev1_r     <= '0;
      prev2_r     <= '0;
      prev3_r     <= '0;
      prev4_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        prev1_r <= b1;
        prev2_r <= b2;
        prev3_r <= b3;
        prev4_r <= b4;
      end
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    out_r   <= out_nxt;
    if (cmd.load) begin
      le1_r <= le1;
      le2_r <= le2;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/srcu_ctrl.sv -----
// controller: sequences the clock pulses and the final strobe of one update
module srcu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srcu_pkg::srcu_stat_t stat,
  output srcu_pkg::srcu_cmd_t  cmd
);

  srcu_pkg::srcu_state_t         state_r, state_nxt;
  logic [srcu_pkg::CntW-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      srcu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = srcu_pkg::ST_SHIFT;
          cnt_nxt   = stat.grp_two_chg ? srcu_pkg::LastGroupTwo : srcu_pkg::LastGroupOne;
        end
      end
      srcu_pkg::ST_SHIFT: begin
        if (stat.slot_free) begin
          if (cnt_r == '0) begin
            state_nxt = srcu_pkg::ST_STROBE;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      srcu_pkg::ST_STROBE: begin
        if (stat.slot_free) begin
          state_nxt = srcu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srcu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      srcu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      srcu_pkg::ST_SHIFT:  cmd.emit_bit    = stat.slot_free;
      srcu_pkg::ST_STROBE: cmd.emit_strobe = stat.slot_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srcu_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/shift_register_chain_updater.sv -----
// Top level of the shift register chain updater.
// One input word carries the control bits of a chain of four 8-bit
// serial-in, parallel-out registers (latch group one: byte one; group two:
// bytes two to four). The block packs the bytes, compares them with the
// previous word and emits one output word per serial clock pulse, then one
// strobe word that names the groups to latch and carries last.
// Channels use valid/stall; a word moves when valid is high and stall low.
// An accepted word yields 9 output words (group two unchanged) or 33 words
// (group two changed). The input is taken in the idle state; the shift state
// then registers one clock pulse word per cycle while the receiver does not
// stall, and the strobe state registers the strobe word. The pulse sequencer
// handles one update at a time.
// A stall on the output holds the registered word and freezes the
// sequencer; in_stall stays high until the strobe word has been produced.
// Reset clears the stored bytes to zero, so the first word after reset
// counts as changed wherever a byte is nonzero.
`include "shift_register_chain_updater_assert.svh"

module shift_register_chain_updater (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srcu_pkg::srcu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srcu_pkg::srcu_out_t out_data
);

  srcu_pkg::srcu_cmd_t  cmd;
  srcu_pkg::srcu_stat_t stat;

  srcu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srcu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SRCU_ASSERT_NOW(a_last_is_strobe, out_valid && out_data.last, out_data.kind, "last word is not a strobe")
  `SRCU_ASSERT_NOW(a_pulse_no_latch, out_valid && !out_data.kind, !out_data.latch_one && !out_data.latch_two && !out_data.last, "latch flags set on a clock pulse word")
  `SRCU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while an update is in progress")
  `SRCU_ASSERT_NOW(a_one_command, 1'b1, $onehot0(cmd), "controller issued conflicting commands")

endmodule
